// ----- design/bmg_pkg.sv -----
// shared constants and types of the box-muller gaussian generator
// no dependencies
`default_nettype none

package bmg_pkg;

  // 2*ln(2) in Q26, rounded
  localparam logic [26:0] TWO_LN2_Q26 = 27'd93032640;
  // pi/2 in Q32 minus 2^32, the part of the constant above one
  localparam logic [31:0] HALF_PI_LO  = 32'd2451551556;
  // one in Q30
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // register stages of each unit
  localparam int unsigned LOG_STAGES  = 32;
  localparam int unsigned SQRT_STAGES = 34;
  localparam int unsigned TRIG_STAGES = 18;

  // sine and cosine of the angle as sign and Q30 magnitude
  typedef struct packed {
    logic        s_neg;
    logic [30:0] s_mag;
    logic        c_neg;
    logic [30:0] c_mag;
  } trig_t;

endpackage

`default_nettype wire

// ----- design/bmg_log.sv -----
// -log2 of the radius draw in Q30, one squaring per stage
// depends on bmg_pkg
`default_nettype none

module bmg_log #(
  parameter int UW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [UW-1:0]             k_i,
  output logic                      valid_o,
  output logic [$clog2(UW+1)+29:0]  l_o
);

  localparam int EW  = $clog2(UW);
  localparam int LW  = $clog2(UW+1) + 30;
  localparam int NSQ = 30;
  localparam int NST = bmg_pkg::LOG_STAGES;

  logic [NST-1:0] valid_q;
  logic [30:0]    m_q    [NSQ+1];
  logic [EW-1:0]  e_q    [NSQ+1];
  logic [29:0]    frac_q [NSQ+1];
  logic [LW-1:0]  l_q;

  logic [UW-1:0]  k_nz;
  logic [EW-1:0]  e_d;
  logic [UW+29:0] norm_w;
  logic [61:0]    sq_w [NSQ];
  logic [LW-1:0]  l_d;

  // leading one and normalised mantissa, zero read as one
  always_comb begin
    k_nz = (k_i == '0) ? {{(UW-1){1'b0}}, 1'b1} : k_i;
    e_d  = '0;
    for (int i = 0; i < UW; i++) begin
      if (k_nz[i]) begin
        e_d = EW'(i);
      end
    end
    norm_w = {k_nz, 30'b0} >> e_d;
  end

  always_comb begin
    for (int j = 0; j < NSQ; j++) begin
      sq_w[j] = 62'(m_q[j]) * 62'(m_q[j]);
    end
    l_d = ((LW'(UW) - LW'(e_q[NSQ])) << 30) - LW'(frac_q[NSQ]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]    <= norm_w[30:0];
      e_q[0]    <= e_d;
      frac_q[0] <= '0;
      for (int j = 0; j < NSQ; j++) begin
        m_q[j+1]    <= sq_w[j][61] ? sq_w[j][61:31] : sq_w[j][60:30];
        e_q[j+1]    <= e_q[j];
        frac_q[j+1] <= frac_q[j] | (sq_w[j][61] ? (30'd1 << (29-j)) : 30'd0);
      end
      l_q <= l_d;
    end
  end

  assign valid_o = valid_q[NST-1];
  assign l_o     = l_q;

`ifndef NO_ASSERTIONS
  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> m_q[0][30])
    else $error("mantissa not normalised");
`endif

endmodule

`default_nettype wire

// ----- design/bmg_sqrt.sv -----
// scaling by 2 ln 2 and bit-serial square root, one result bit per stage
// depends on bmg_pkg
`default_nettype none

module bmg_sqrt #(
  parameter int UW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [$clog2(UW+1)+29:0]  l_i,
  output logic                      valid_o,
  output logic [31:0]               r_o
);

  localparam int LW  = $clog2(UW+1) + 30;
  localparam int HW  = LW - 18;
  localparam int NIT = 32;
  localparam int NST = bmg_pkg::SQRT_STAGES;

  logic [NST-1:0]  valid_q;
  logic [44:0]     plo_q;
  logic [HW+26:0]  phi_q;
  logic [63:0]     v_q   [NIT];
  logic [63:0]     res_q [NIT+1];

  logic [63:0]     cand_w [NIT];
  logic [NIT-1:0]  ge_w;

  always_comb begin
    for (int i = 0; i < NIT; i++) begin
      cand_w[i] = res_q[i] + (64'd1 << (62 - 2*i));
      ge_w[i]   = (v_q[i] >= cand_w[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // product split in two partial products
      plo_q    <= 45'(l_i[17:0]) * 45'(bmg_pkg::TWO_LN2_Q26);
      phi_q    <= (HW+27)'(l_i[LW-1:18]) * (HW+27)'(bmg_pkg::TWO_LN2_Q26);
      v_q[0]   <= (64'(phi_q) << 18) + 64'(plo_q);
      res_q[0] <= '0;
      for (int i = 0; i < NIT; i++) begin
        if (ge_w[i]) begin
          res_q[i+1] <= (res_q[i] >> 1) + (64'd1 << (62 - 2*i));
        end else begin
          res_q[i+1] <= res_q[i] >> 1;
        end
      end
      for (int i = 0; i < NIT-1; i++) begin
        v_q[i+1] <= ge_w[i] ? (v_q[i] - cand_w[i]) : v_q[i];
      end
    end
  end

  assign valid_o = valid_q[NST-1];
  assign r_o     = res_q[NIT][31:0];

`ifndef NO_ASSERTIONS
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_q[NIT][63:31] == '0))
    else $error("radius out of range");
`endif

endmodule

`default_nettype wire

// ----- design/bmg_trig.sv -----
// octant reduction and taylor sine and cosine, one multiply or divide per stage
// depends on bmg_pkg
`default_nettype none

module bmg_trig #(
  parameter int UW = 32
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [UW-1:0]     u_i,
  output bmg_pkg::trig_t    trig_o
);

  typedef enum logic [1:0] {Q_FIRST, Q_SECOND, Q_THIRD, Q_FOURTH} quad_e;

  localparam int NT = 7;
  localparam int NQ = bmg_pkg::TRIG_STAGES - 1;

  logic [31:0]        t_w;
  logic [30:0]        fr_d;
  logic [61:0]        hp_w;
  logic [59:0]        xx_w;

  logic [2:0]         qf_q  [NQ];
  logic [29:0]        fr_q;
  logic [29:0]        x1_q;

  logic [29:0]        x2_q  [NT];
  logic [30:0]        ts_q  [NT];
  logic [30:0]        tc_q  [NT];
  logic signed [31:0] as_q  [NT+1];
  logic signed [31:0] ac_q  [NT+1];

  logic [29:0]        x2a_q [NT-1];
  logic [29:0]        ps_q  [NT];
  logic [29:0]        pc_q  [NT];
  logic signed [31:0] asa_q [NT];
  logic signed [31:0] aca_q [NT];

  logic [60:0]        ms_w  [NT];
  logic [60:0]        mc_w  [NT];
  logic [29:0]        qs_w  [NT];
  logic [29:0]        qc_w  [NT];

  bmg_pkg::trig_t     trig_d;
  bmg_pkg::trig_t     trig_q;
  logic signed [31:0] sa, ca, s_val, c_val;
  logic               s_n, c_n;

  // angle as 32-bit fraction of a turn
  if (UW >= 32) begin : g_wide
    assign t_w = u_i[UW-1 -: 32];
  end else begin : g_narrow
    assign t_w = {u_i, {(32-UW){1'b0}}};
  end

  assign fr_d = t_w[29] ? (31'h4000_0000 - {1'b0, t_w[29:0]}) : {1'b0, t_w[29:0]};
  assign hp_w = 62'(fr_q) * 62'(bmg_pkg::HALF_PI_LO);
  assign xx_w = 60'(x1_q) * 60'(x1_q);

  // floor division by each taylor factor through an exact reciprocal
  for (genvar i = 0; i < NT; i++) begin : g_div
    localparam int DS = (2*i + 2) * (2*i + 3);
    localparam int DC = (2*i + 1) * (2*i + 2);
    localparam int LS = $clog2(DS);
    localparam int LC = $clog2(DC);
    localparam logic [63:0] MS = ((64'd1 << (30 + LS)) + 64'(DS) - 64'd1) / 64'(DS);
    localparam logic [63:0] MC = ((64'd1 << (30 + LC)) + 64'(DC) - 64'd1) / 64'(DC);
    logic [60:0] rs, rc;
    assign rs      = 61'(ps_q[i]) * 61'(MS[30:0]);
    assign rc      = 61'(pc_q[i]) * 61'(MC[30:0]);
    assign qs_w[i] = 30'(rs >> (30 + LS));
    assign qc_w[i] = 30'(rc >> (30 + LC));
  end

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      ms_w[i] = 61'(ts_q[i]) * 61'(x2_q[i]);
      mc_w[i] = 61'(tc_q[i]) * 61'(x2_q[i]);
    end
  end

  // octant fold, quadrant swap and sign
  always_comb begin
    sa    = qf_q[NQ-1][0] ? ac_q[NT] : as_q[NT];
    ca    = qf_q[NQ-1][0] ? as_q[NT] : ac_q[NT];
    s_val = sa;
    c_val = ca;
    s_n   = 1'b0;
    c_n   = 1'b0;
    case (quad_e'(qf_q[NQ-1][2:1]))
      Q_FIRST: begin
        s_val = sa;  c_val = ca;  s_n = 1'b0; c_n = 1'b0;
      end
      Q_SECOND: begin
        s_val = ca;  c_val = sa;  s_n = 1'b0; c_n = 1'b1;
      end
      Q_THIRD: begin
        s_val = sa;  c_val = ca;  s_n = 1'b1; c_n = 1'b1;
      end
      Q_FOURTH: begin
        s_val = ca;  c_val = sa;  s_n = 1'b1; c_n = 1'b0;
      end
      default: begin
        s_val = sa;  c_val = ca;  s_n = 1'b0; c_n = 1'b0;
      end
    endcase
    trig_d.s_neg = s_n && (s_val != '0);
    trig_d.s_mag = s_val[30:0];
    trig_d.c_neg = c_n && (c_val != '0);
    trig_d.c_mag = c_val[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qf_q[0] <= t_w[31:29];
      for (int j = 1; j < NQ; j++) begin
        qf_q[j] <= qf_q[j-1];
      end
      fr_q    <= fr_d[29:0];
      x1_q    <= fr_q + hp_w[61:32];
      x2_q[0] <= xx_w[59:30];
      ts_q[0] <= {1'b0, x1_q};
      tc_q[0] <= bmg_pkg::ONE_Q30;
      as_q[0] <= signed'(32'(x1_q));
      ac_q[0] <= signed'(32'(bmg_pkg::ONE_Q30));
      for (int i = 0; i < NT; i++) begin
        ps_q[i]  <= ms_w[i][59:30];
        pc_q[i]  <= mc_w[i][59:30];
        asa_q[i] <= as_q[i];
        aca_q[i] <= ac_q[i];
        if ((i % 2) == 0) begin
          as_q[i+1] <= asa_q[i] - signed'(32'(qs_w[i]));
          ac_q[i+1] <= aca_q[i] - signed'(32'(qc_w[i]));
        end else begin
          as_q[i+1] <= asa_q[i] + signed'(32'(qs_w[i]));
          ac_q[i+1] <= aca_q[i] + signed'(32'(qc_w[i]));
        end
      end
      for (int i = 0; i < NT-1; i++) begin
        x2a_q[i]  <= x2_q[i];
        x2_q[i+1] <= x2a_q[i];
        ts_q[i+1] <= 31'(qs_w[i]);
        tc_q[i+1] <= 31'(qc_w[i]);
      end
      trig_q <= trig_d;
    end
  end

  assign trig_o = trig_q;

endmodule

`default_nettype wire

// ----- design/bmg_scale.sv -----
// radius times sine and cosine, rounding and saturation to the sample format
// depends on bmg_pkg
`default_nettype none

module bmg_scale #(
  parameter int SW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [31:0]          r_i,
  input  bmg_pkg::trig_t       trig_i,
  output logic                 valid_o,
  output logic signed [SW-1:0] z_sin_o,
  output logic signed [SW-1:0] z_cos_o
);

  localparam int SH = 62 - SW;
  localparam logic [SW+1:0] MAX_POS = (SW+2)'((64'd1 << (SW-1)) - 64'd1);
  localparam logic [SW+1:0] MAX_NEG = (SW+2)'(64'd1 << (SW-1));

  logic [1:0]    valid_q;
  logic [62:0]   ps_q, pc_q;
  logic          sn_q, cn_q;
  logic [SW-1:0] zs_q, zc_q;

  function automatic logic [SW-1:0] round_sat(input logic [62:0] p, input logic neg);
    logic [63:0]   sum;
    logic [SW+1:0] mag;
    sum = 64'(p) + (64'd1 << (SH-1));
    mag = (SW+2)'(sum >> SH);
    if (neg) begin
      if (mag > MAX_NEG) begin
        mag = MAX_NEG;
      end
      return SW'(~mag + 1'b1);
    end else begin
      if (mag > MAX_POS) begin
        mag = MAX_POS;
      end
      return SW'(mag);
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ps_q <= 63'(trig_i.s_mag) * 63'(r_i);
      pc_q <= 63'(trig_i.c_mag) * 63'(r_i);
      sn_q <= trig_i.s_neg;
      cn_q <= trig_i.c_neg;
      zs_q <= round_sat(ps_q, sn_q);
      zc_q <= round_sat(pc_q, cn_q);
    end
  end

  assign valid_o = valid_q[1];
  assign z_sin_o = signed'(zs_q);
  assign z_cos_o = signed'(zc_q);

endmodule

`default_nettype wire

// ----- design/box_muller_gaussian.sv -----
// Box-Muller gaussian noise generator. Each transaction on the input carries
// a pair of uniform draws (unsigned fractions of one) and gives one output
// transaction with two independent normal samples, radius times sine and
// radius times cosine, signed with SAMPLE_WIDTH-4 fraction bits. A radius
// draw of zero is read as the smallest nonzero fraction. The block takes a
// new transaction every clock while it is not frozen. The radius path holds
// 32 stages of logarithm (a mantissa squaring in all but the first and
// last), 34 stages of scaling and square root (one root bit per stage) and
// 2 output stages. The angle path (18 stages) is delayed to line up with
// it. The whole pipeline advances together and freezes only while a result
// sits in the output register with out_stall_i high.
// depends on bmg_pkg, bmg_log, bmg_sqrt, bmg_trig, bmg_scale
`default_nettype none

module box_muller_gaussian #(
  parameter int UNIFORM_WIDTH = 32,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [UNIFORM_WIDTH-1:0]       u_radius_i,
  input  logic [UNIFORM_WIDTH-1:0]       u_angle_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] z_sin_o,
  output logic signed [SAMPLE_WIDTH-1:0] z_cos_o
);

  localparam int LW  = $clog2(UNIFORM_WIDTH+1) + 30;
  // extra stages that line the angle path up with the radius path
  localparam int DLY = bmg_pkg::LOG_STAGES + bmg_pkg::SQRT_STAGES
                     - bmg_pkg::TRIG_STAGES;

  logic            en_w;
  logic            log_valid, rad_valid;
  logic [LW-1:0]   log_l;
  logic [31:0]     rad_r;
  bmg_pkg::trig_t  trig_w;
  bmg_pkg::trig_t  dly_q [DLY];

  // the pipeline holds only while the output register is blocked
  assign en_w       = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en_w;

  // radius path: -log2 of the first draw
  bmg_log #(
    .UW (UNIFORM_WIDTH)
  ) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_w),
    .valid_i (in_valid_i),
    .k_i     (u_radius_i),
    .valid_o (log_valid),
    .l_o     (log_l)
  );

  // radius path: sqrt(2 ln2 * -log2 u) in Q28
  bmg_sqrt #(
    .UW (UNIFORM_WIDTH)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_w),
    .valid_i (log_valid),
    .l_i     (log_l),
    .valid_o (rad_valid),
    .r_o     (rad_r)
  );

  // angle path: sine and cosine of the second draw
  bmg_trig #(
    .UW (UNIFORM_WIDTH)
  ) u_trig (
    .clk_i  (clk_i),
    .en_i   (en_w),
    .u_i    (u_angle_i),
    .trig_o (trig_w)
  );

  // delay line for the angle results, no control state in it
  always_ff @(posedge clk_i) begin
    if (en_w) begin
      dly_q[0] <= trig_w;
      for (int j = 1; j < DLY; j++) begin
        dly_q[j] <= dly_q[j-1];
      end
    end
  end

  // product, rounding and the output register
  bmg_scale #(
    .SW (SAMPLE_WIDTH)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_w),
    .valid_i (rad_valid),
    .r_i     (rad_r),
    .trig_i  (dly_q[DLY-1]),
    .valid_o (out_valid_o),
    .z_sin_o (z_sin_o),
    .z_cos_o (z_cos_o)
  );

`ifndef NO_ASSERTIONS
  a_trig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rad_valid |-> ((dly_q[DLY-1].s_mag <= bmg_pkg::ONE_Q30) &&
                   (dly_q[DLY-1].c_mag <= bmg_pkg::ONE_Q30)))
    else $error("sine or cosine magnitude above one");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench of the box-muller gaussian generator: directed table then random draws,
// every output checked against a typed result or an integer predictor of the transform
// depends on bmg_pkg and box_muller_gaussian
`timescale 1ns / 1ps

module tb_top;

  localparam int UW = 32;
  localparam int SW = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [UW-1:0] u_radius_i = '0;
  logic [UW-1:0] u_angle_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SW-1:0] z_sin_o, z_cos_o;

  always #1 clk_i = ~clk_i;

  box_muller_gaussian #(.UNIFORM_WIDTH(UW), .SAMPLE_WIDTH(SW)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .u_radius_i, .u_angle_i,
    .out_valid_o, .out_stall_i, .z_sin_o, .z_cos_o
  );

  typedef struct packed {
    logic [SW-1:0] zs;
    logic [SW-1:0] zc;
  } sample_pair_t;

  sample_pair_t pending_samples[$];
  int  n_errors = 0;
  bit  feed_done = 1'b0;
  bit  hold_off = 1'b0;

  // integer square root, floor
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // radius sqrt(-2 ln(k/2^32)) in Q28
  function automatic logic [63:0] radius_of(input logic [63:0] k);
    int e;
    logic [63:0] m, frac, lq;
    e = 0;
    frac = 0;
    for (int i = 0; i < 64; i++) if (k[i]) e = i;
    m = (e >= 30) ? (k >> (e - 30)) : (k << (30 - e));
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m >>= 1;
        frac[i] = 1'b1;
      end
    end
    lq = (64'(UW - e) << 30) - frac;
    return root_floor(lq * 64'(bmg_pkg::TWO_LN2_Q26));
  endfunction

  // sine and cosine in Q30 of x in [0, pi/4]
  function automatic void octant_trig(input logic [63:0] x, output longint s,
                                      output longint c);
    logic [63:0] x2, ts, tc;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'(bmg_pkg::ONE_Q30);
    s = longint'(x);
    c = longint'(64'(bmg_pkg::ONE_Q30));
    for (int n = 1; n <= 7; n++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        s -= longint'(ts);
        c -= longint'(tc);
      end else begin
        s += longint'(ts);
        c += longint'(tc);
      end
    end
  endfunction

  function automatic logic [SW-1:0] scale_sample(input logic [63:0] r, input longint t);
    localparam int SH = 58 - (SW - 4);
    logic [63:0] mag, maxv;
    bit neg;
    neg = t < 0;
    maxv = (64'd1 << (SW - 1)) - 1;
    mag = 64'(neg ? -t : t) * r;
    mag = (mag + (64'd1 << (SH - 1))) >> SH;
    if (neg) begin
      if (mag > maxv + 1) mag = maxv + 1;
      return SW'(-mag);
    end
    if (mag > maxv) mag = maxv;
    return SW'(mag);
  endfunction

  function automatic sample_pair_t gaussian_pair(input logic [UW-1:0] ur,
                                                 input logic [UW-1:0] ua);
    localparam logic [63:0] HALF_PI = 64'd6746518852;
    logic [63:0] k, r, f, one;
    longint ps, pc, sa, ca, zs, zc;
    sample_pair_t p;
    one = 64'(bmg_pkg::ONE_Q30);
    k = 64'(ur);
    if (k == 0) k = 1; // zero draw read as smallest fraction
    r = radius_of(k);
    f = 64'(ua) & (one - 1);
    if (f >= (one >> 1)) begin
      octant_trig(((one - f) * HALF_PI) >> 32, ps, pc);
      sa = pc;
      ca = ps;
    end else begin
      octant_trig((f * HALF_PI) >> 32, ps, pc);
      sa = ps;
      ca = pc;
    end
    case (ua[31:30])
      2'd0: begin zs = sa;  zc = ca;  end
      2'd1: begin zs = ca;  zc = -sa; end
      2'd2: begin zs = -sa; zc = -ca; end
      default: begin zs = -ca; zc = sa; end
    endcase
    p.zs = scale_sample(r, zs);
    p.zc = scale_sample(r, zc);
    return p;
  endfunction

  // directed rows: typed result only where obvious, else predictor
  typedef struct {
    logic [UW-1:0] ur;
    logic [UW-1:0] ua;
    bit            typed;
    sample_pair_t  want;
  } draw_row_t;

  draw_row_t draw_table[] = '{
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{16'sd0, 16'sd0}}, // radius near zero
    '{32'h0000_0000, 32'h0000_0000, 1'b0, '0},                // zero draw, angle 0
    '{32'h0000_0001, 32'h4000_0000, 1'b0, '0},                // same radius, quarter turn
    '{32'h0000_0000, 32'h8000_0000, 1'b0, '0},
    '{32'h0000_0000, 32'hC000_0000, 1'b0, '0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'h8000_0000, 32'h2000_0000, 1'b0, '0},                // octant boundary
    '{32'h8000_0000, 32'h1FFF_FFFF, 1'b0, '0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{32'h0000_0002, 32'h6000_0000, 1'b0, '0},
    '{32'h0001_0000, 32'hE000_0001, 1'b0, '0},
    '{32'h7FFF_FFFF, 32'h3FFF_FFFF, 1'b0, '0},
    '{32'h0000_FFFF, 32'h9FFF_FFFF, 1'b0, '0}
  };

  // offer one transaction and hold it until taken, with a random gap first
  task automatic send_draw(input logic [UW-1:0] ur, input logic [UW-1:0] ua,
                           input sample_pair_t want);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) :
          (($urandom_range(0, 49) == 0) ? $urandom_range(10, 40) : 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    u_radius_i <= ur;
    u_angle_i  <= ua;
    pending_samples.push_back(want);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stimulus
  initial begin
    logic [UW-1:0] ur, ua;
    int mode;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (draw_table[i])
      send_draw(draw_table[i].ur, draw_table[i].ua,
                draw_table[i].typed ? draw_table[i].want
                                    : gaussian_pair(draw_table[i].ur, draw_table[i].ua));
    for (int n = 0; n < 1300; n++) begin
      mode = $urandom_range(0, 9);
      ur = $urandom();
      ua = $urandom();
      // small draws reach large radii, a whole range of exponents
      if (mode < 3) ur = ur >> $urandom_range(0, 31);
      else if (mode == 3) ur = $urandom_range(0, 3);
      if (n == 300) hold_off = 1'b1;
      if (n == 400) hold_off = 1'b0;
      send_draw(ur, ua, gaussian_pair(ur, ua));
    end
    in_valid_i <= 1'b0;
    feed_done = 1'b1;
  end

  // receiver stall: random gaps plus one long hold-off to fill the pipeline
  initial begin
    int len;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        out_stall_i <= 1'b0;
        wait (!hold_off);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) :
              (($urandom_range(0, 99) == 0) ? $urandom_range(20, 60) : 0);
        if (len > 0) begin
          out_stall_i <= 1'b1;
          repeat (len) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    sample_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected output sin %0d cos %0d", $time, z_sin_o, z_cos_o);
        n_errors++;
      end else begin
        want = pending_samples.pop_front();
        if (z_sin_o !== want.zs) begin
          $display("%0t: z_sin expected %0d actual %0d", $time, $signed(want.zs), z_sin_o);
          n_errors++;
        end
        if (z_cos_o !== want.zc) begin
          $display("%0t: z_cos expected %0d actual %0d", $time, $signed(want.zc), z_cos_o);
          n_errors++;
        end
      end
    end
  end

  // end of run once the pipeline has drained
  initial begin
    wait (feed_done);
    wait (pending_samples.size() == 0);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0 && pending_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bmg_pkg.sv
design/bmg_log.sv
design/bmg_sqrt.sv
design/bmg_trig.sv
design/bmg_scale.sv
design/box_muller_gaussian.sv
tb/tb_top.sv
